// ===== hdl/bsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Shared types, codes and a helper function for the slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int WORD_BITS = 32;

    typedef enum logic [1:0] {
        ACT_PUT  = 2'd0,
        ACT_GET  = 2'd1,
        ACT_FREE = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOOKUP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic scan_next;
        logic issue_read;
        logic early_done;
        logic commit;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic op_put;
        logic op_access;
        logic range_err;
        logic scan_hit;
        logic scan_last;
        logic out_room;
    } t_sts;

    // Position of the lowest zero bit; the caller checks that one exists.
    function automatic logic [4:0] ffz32(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] v;
        logic [4:0]           p;
        v = ~w;
        p = '0;
        if (v[15:0] == 16'd0) begin
            p[4] = 1'b1;
            v    = v >> 16;
        end
        if (v[7:0] == 8'd0) begin
            p[3] = 1'b1;
            v    = v >> 8;
        end
        if (v[3:0] == 4'd0) begin
            p[2] = 1'b1;
            v    = v >> 4;
        end
        if (v[1:0] == 2'd0) begin
            p[1] = 1'b1;
            v    = v >> 2;
        end
        if (v[0] == 1'b0) begin
            p[0] = 1'b1;
        end
        return p;
    endfunction

endpackage

// ===== hdl/bsa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface bsa_req_if;
    logic                    valid;
    logic                    ready;
    bsa_pkg::t_action        action;
    logic signed [6:0]       slot_index;
    logic        [31:0]      item_value;

    modport source (output valid, output action, output slot_index, output item_value,
                    input ready);
    modport sink   (input valid, input action, input slot_index, input item_value,
                    output ready);
endinterface

interface bsa_rsp_if;
    logic                    valid;
    logic                    ready;
    bsa_pkg::t_status        status;
    logic        [5:0]       granted_index;
    logic        [31:0]      read_value;
    logic        [6:0]       occupied_count;

    modport source (output valid, output status, output granted_index,
                    output read_value, output occupied_count, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input read_value, input occupied_count, output ready);
endinterface

// ===== hdl/bsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator controller
// Sequences acceptance, free-word scan, lookup, commit and result hand-off.
// ----------------------------------------------------------------------------
module bsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bsa_pkg::t_sts i_sts,
    output bsa_pkg::t_cmd o_cmd
);
    import bsa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (i_sts.op_put) begin
                    if (i_sts.scan_hit) begin
                        n_state = S_LOOKUP;
                    end else if (i_sts.scan_last) begin
                        n_state = S_DONE;
                    end
                end else if (i_sts.op_access && !i_sts.range_err) begin
                    n_state = S_LOOKUP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LOOKUP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_room) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take = 1'b1;
            end
            S_EXEC: begin
                priority if (i_sts.op_put) begin
                    if (i_sts.scan_hit) begin
                        o_cmd.issue_read = 1'b1;
                    end else if (i_sts.scan_last) begin
                        o_cmd.early_done = 1'b1;
                    end else begin
                        o_cmd.scan_next = 1'b1;
                    end
                end else if (i_sts.op_access && !i_sts.range_err) begin
                    o_cmd.issue_read = 1'b1;
                end else begin
                    o_cmd.early_done = 1'b1;
                end
            end
            S_LOOKUP: begin
                o_cmd.commit = 1'b1;
            end
            S_DONE: begin
                o_cmd.emit = i_sts.out_room;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/bsa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator datapath
// Occupancy bitmap, entry store, full-word scan, counter and output register.
// ----------------------------------------------------------------------------
module bsa_dp #(
    parameter int SLOTS      = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsa_req_if.sink       i_req,
    bsa_rsp_if.source     o_rsp,
    input  bsa_pkg::t_cmd i_cmd,
    output bsa_pkg::t_sts o_sts
);
    import bsa_pkg::*;

    localparam int WORDS    = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int CAPACITY = WORDS * WORD_BITS;
    localparam int WORD_AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SLOT_AW  = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int NCHUNK   = (WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int CHUNK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int EW       = SLOT_AW + 3;
    localparam int VW       = (ITEM_WIDTH > 32) ? ITEM_WIDTH : 32;
    localparam int SW6      = (SLOT_AW > 6) ? SLOT_AW : 6;
    localparam int CW7      = (CNT_W > 7) ? CNT_W : 7;

    t_action             r_action;
    logic signed [6:0]   r_idx;
    logic [31:0]         r_item;
    logic [CHUNK_W-1:0]  r_chunk;
    logic [WORD_AW-1:0]  r_word_addr;
    logic [SLOT_AW-1:0]  r_slot;
    logic [WORDS-1:0]    r_full;
    logic [WORDS-1:0]    r_wvalid;
    logic [CNT_W-1:0]    r_count;
    t_status             r_status;
    logic [SLOT_AW-1:0]  r_index;
    logic [31:0]         r_value;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [5:0]          r_out_index;
    logic [31:0]         r_out_value;
    logic [6:0]          r_out_count;

    logic                    op_put;
    logic                    op_access;
    logic                    op_free;
    logic [EW-1:0]           idx_ext;
    logic [EW-1:0]           idx_sum;
    logic                    range_err;
    logic [SLOT_AW-1:0]      abs_slot;
    logic [WORD_AW+4:0]      abs_ext;
    logic [NCHUNK*WORD_BITS-1:0] full_pad;
    logic [WORD_BITS-1:0]    chunk;
    logic [4:0]              chunk_pos;
    logic [CHUNK_W+4:0]      scan_ext;
    logic [WORD_AW-1:0]      scan_addr;
    logic [WORD_AW-1:0]      rd_word_addr;
    logic [WORD_BITS-1:0]    bm_rdata;
    logic [WORD_BITS-1:0]    word;
    logic [4:0]              put_bit;
    logic [WORD_AW+4:0]      put_ext;
    logic [SLOT_AW-1:0]      put_slot;
    logic                    hit_bit;
    logic [WORD_BITS-1:0]    bm_wdata;
    logic                    bm_we;
    logic [VW-1:0]           item_ext;
    logic [ITEM_WIDTH-1:0]   ent_rdata;
    logic [VW-1:0]           ent_ext;
    logic                    ent_we;
    logic                    accept;
    logic [SW6-1:0]          index_ext;
    logic [CW7-1:0]          count_ext;

    assign op_put    = (r_action == ACT_PUT);
    assign op_free   = (r_action == ACT_FREE);
    assign op_access = (r_action == ACT_GET) || op_free;
    assign accept    = i_cmd.take && i_req.valid;

    // Backward counts are taken from the end of the table.
    assign idx_ext   = {{(EW - 7){r_idx[6]}}, r_idx};
    assign idx_sum   = r_idx[6] ? (idx_ext + EW'(CAPACITY)) : idx_ext;
    assign range_err = idx_sum[EW-1] || (idx_sum[EW-2:0] >= (EW - 1)'(CAPACITY));
    assign abs_slot  = idx_sum[SLOT_AW-1:0];
    assign abs_ext   = (WORD_AW + 5)'(abs_slot);

    always_comb begin
        full_pad              = '1;
        full_pad[WORDS-1:0]   = r_full;
    end

    assign chunk     = full_pad[r_chunk*WORD_BITS +: WORD_BITS];
    assign chunk_pos = ffz32(chunk);
    assign scan_ext  = {r_chunk, chunk_pos};
    assign scan_addr = scan_ext[WORD_AW-1:0];
    assign rd_word_addr = op_put ? scan_addr : abs_ext[WORD_AW+4:5];

    assign word     = r_wvalid[r_word_addr] ? bm_rdata : '0;
    assign put_bit  = ffz32(word);
    assign put_ext  = {r_word_addr, put_bit};
    assign put_slot = put_ext[SLOT_AW-1:0];
    assign hit_bit  = word[r_slot[4:0]];
    assign bm_wdata = op_put ? (word | (WORD_BITS'(1) << put_bit))
                             : (word & ~(WORD_BITS'(1) << r_slot[4:0]));
    assign bm_we    = i_cmd.commit && (op_put || (op_free && hit_bit));
    assign ent_we   = i_cmd.commit && op_put;
    assign item_ext = VW'(r_item);
    assign ent_ext  = VW'(ent_rdata);

    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (r_word_addr),
        .i_wdata (bm_wdata),
        .i_re    (i_cmd.issue_read),
        .i_raddr (rd_word_addr),
        .o_rdata (bm_rdata)
    );

    bsa_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (put_slot),
        .i_wdata (item_ext[ITEM_WIDTH-1:0]),
        .i_re    (i_cmd.issue_read),
        .i_raddr (abs_slot),
        .o_rdata (ent_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_req.action;
            r_idx    <= i_req.slot_index;
            r_item   <= i_req.item_value;
        end
        if (i_cmd.issue_read) begin
            r_word_addr <= rd_word_addr;
            r_slot      <= abs_slot;
        end
        if (i_cmd.early_done) begin
            r_status <= op_put ? ST_FULL : (op_access ? ST_RANGE : ST_OK);
            r_index  <= '0;
            r_value  <= '0;
        end else if (i_cmd.commit) begin
            if (op_put) begin
                r_status <= ST_OK;
                r_index  <= put_slot;
                r_value  <= '0;
            end else begin
                r_status <= hit_bit ? ST_OK : ST_EMPTY;
                r_index  <= r_slot;
                r_value  <= hit_bit ? ent_ext[31:0] : 32'd0;
            end
        end
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_index  <= index_ext[5:0];
            r_out_value  <= r_value;
            r_out_count  <= count_ext[6:0];
        end
    end

    assign index_ext = SW6'(r_index);
    assign count_ext = CW7'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk     <= '0;
            r_full      <= '0;
            r_wvalid    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_chunk <= '0;
            end else if (i_cmd.scan_next) begin
                r_chunk <= r_chunk + CHUNK_W'(1);
            end
            if (bm_we) begin
                r_wvalid[r_word_addr] <= 1'b1;
                r_full[r_word_addr]   <= &bm_wdata;
            end
            if (i_cmd.commit && op_put) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.commit && op_free && hit_bit) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_req.ready          = i_cmd.take;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.granted_index  = r_out_index;
    assign o_rsp.read_value     = r_out_value;
    assign o_rsp.occupied_count = r_out_count;

    assign o_sts.in_valid  = i_req.valid;
    assign o_sts.op_put    = op_put;
    assign o_sts.op_access = op_access;
    assign o_sts.range_err = range_err;
    assign o_sts.scan_hit  = ~&chunk;
    assign o_sts.scan_last = (r_chunk == CHUNK_W'(NCHUNK - 1));
    assign o_sts.out_room  = !r_out_valid || o_rsp.ready;

endmodule

// ===== hdl/bitmap_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// Slot table with an occupancy bitmap and lowest-free-slot allocation.
// ----------------------------------------------------------------------------
// Requests arrive on i_req as words of action, slot_index and item_value, and
// each one produces exactly one response word on o_rsp with status,
// granted_index, read_value and occupied_count. A put claims the lowest free
// slot, a get reads an occupied slot and a free reads and releases it.
// The block handles one request at a time. A put, get or free goes through the
// states S_IDLE, S_EXEC, S_LOOKUP and S_DONE before the next request is taken,
// and its response is registered in S_DONE. An ignored action, an index out of
// range or a put to a full table skips the memory read and S_LOOKUP. A put
// searches the full-word flags one group of 1024 slots at a time until it finds
// a word that is not full. The path is set by the registered reads of the
// bitmap and entry memories.
// Reset clears the bitmap valid and full flags and the occupied count at once,
// so the table starts empty and the first request is taken right after reset.
// The output register holds a response until it is taken; while the receiver
// stalls, the next request is still accepted and worked on, and its response
// waits for the output register to empty.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
    parameter int SLOTS      = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsa_req_if.sink   i_req,
    bsa_rsp_if.source o_rsp
);
    import bsa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bsa_dp #(
        .SLOTS      (SLOTS),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

`ifndef ASSERT_OFF
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.take, cmd.scan_next, cmd.issue_read, cmd.early_done,
                  cmd.commit, cmd.emit}))
        else $error("controller issued more than one command");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in progress");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_rsp.valid || o_rsp.ready))
        else $error("response register overwritten before it was taken");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_FULL || o_rsp.status == ST_RANGE))
            |-> (o_rsp.granted_index == 6'd0 && o_rsp.read_value == 32'd0))
        else $error("failed request carries a slot or a value");
`endif

endmodule

// ===== tb/bitmap_slot_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator testbench
// Drives put, get and free requests into the allocator, keeps its own copy of
// the occupancy bitmap and the slot contents, and checks every response word
// in order against the predicted status, slot, value and occupied count.
// Random traffic fills the table to refusal, drains it and mixes operations,
// while both handshake sides stall at random.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_tb;
    import bsa_pkg::*;

    localparam int TABLE_SLOTS = 64;
    localparam int WORD_COUNT  = TABLE_SLOTS / 32;
    localparam int ITEM_TARGET = 450;
    localparam int LONG_HOLD   = 150;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 50;

    class slot_ledger;
        typedef struct {
            t_status     status;
            logic [5:0]  slot;
            logic [31:0] value;
            logic [6:0]  count;
        } t_reply;

        bit   [31:0] occ_words [WORD_COUNT];
        logic [31:0] held [TABLE_SLOTS];
        int          occupied;
        t_reply      expected_replies [$];
        int          mismatches;
        int          replies_seen;
        int          puts, gets, frees, full_refusals, empty_hits, idle_words, peak;

        function new();
            foreach (occ_words[w]) occ_words[w] = '0;
            foreach (held[s]) held[s] = '0;
            occupied = 0;
        endfunction

        function bit is_taken(int s);
            return occ_words[s / 32][s % 32];
        endfunction

        function int lowest_free();
            for (int w = 0; w < WORD_COUNT; w++) begin
                if (occ_words[w] != '1) begin
                    for (int b = 0; b < 32; b++) begin
                        if (!occ_words[w][b]) return w * 32 + b;
                    end
                end
            end
            return -1;
        endfunction

        function int pick_taken();
            int taken [$];
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                if (is_taken(s)) taken.push_back(s);
            end
            if (taken.size() == 0) return -1;
            return taken[$urandom_range(0, taken.size() - 1)];
        endfunction

        function void note_request(t_action act, logic signed [6:0] idx, logic [31:0] val);
            t_reply r;
            int     s;
            r.status = ST_OK;
            r.slot   = '0;
            r.value  = '0;
            case (act)
                ACT_PUT: begin
                    puts++;
                    s = lowest_free();
                    if (s < 0) begin
                        r.status = ST_FULL;
                        full_refusals++;
                    end else begin
                        occ_words[s / 32][s % 32] = 1'b1;
                        held[s] = val;
                        occupied++;
                        r.slot = s[5:0];
                    end
                end
                ACT_GET, ACT_FREE: begin
                    if (act == ACT_GET) gets++;
                    else frees++;
                    s = idx;
                    if (s < 0) s += TABLE_SLOTS;
                    if (s < 0 || s >= TABLE_SLOTS) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.slot = s[5:0];
                        if (!is_taken(s)) begin
                            r.status = ST_EMPTY;
                            empty_hits++;
                        end else begin
                            r.value = held[s];
                            if (act == ACT_FREE) begin
                                occ_words[s / 32][s % 32] = 1'b0;
                                held[s] = '0;
                                occupied--;
                            end
                        end
                    end
                end
                default: idle_words++;
            endcase
            r.count = occupied[6:0];
            if (occupied > peak) peak = occupied;
            expected_replies.push_back(r);
        endfunction

        task report(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("ERROR at %0t: response %0d, %s expected 0x%0h, got 0x%0h",
                         $time, replies_seen, field, want, got);
        endtask

        task check_response(t_status st, logic [5:0] slot, logic [31:0] value,
                            logic [6:0] count);
            t_reply r;
            replies_seen++;
            if (expected_replies.size() == 0) begin
                report("unexpected word, status", '0, st);
            end else begin
                r = expected_replies.pop_front();
                if (st !== r.status) report("status", r.status, st);
                if (slot !== r.slot) report("granted_index", r.slot, slot);
                if (value !== r.value) report("read_value", r.value, value);
                if (count !== r.count) report("occupied_count", r.count, count);
            end
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    bsa_req_if  req_ch ();
    bsa_rsp_if  rsp_ch ();
    slot_ledger ledger;
    bit         calm;
    bit         long_hold_done;
    int         work_words;
    int         cycle_count;

    bitmap_slot_allocator #(
        .SLOTS      (TABLE_SLOTS),
        .ITEM_WIDTH (32)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [6:0] as_index(int s);
        int v;
        v = $urandom_range(0, 1) ? s - TABLE_SLOTS : s;
        return v[6:0];
    endfunction

    task automatic rest(int n);
        repeat (n) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
    endtask

    task automatic send_word(t_action act, logic signed [6:0] idx, logic [31:0] val);
        @(negedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.slot_index <= idx;
        req_ch.item_value <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        ledger.note_request(act, idx, val);
        if (act != ACT_NONE) work_words++;
        rest(gap_len());
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (ledger.expected_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic mixed_word();
        int r;
        int s;
        r = $urandom_range(0, 99);
        s = ledger.pick_taken();
        if (r < 35) send_word(ACT_PUT, 7'($urandom), $urandom);
        else if (r < 60 && s >= 0) send_word(ACT_GET, as_index(s), $urandom);
        else if (r < 80 && s >= 0) send_word(ACT_FREE, as_index(s), $urandom);
        else if (r < 88) send_word(ACT_GET, 7'($urandom), $urandom);
        else if (r < 96) send_word(ACT_FREE, 7'($urandom), $urandom);
        else send_word(ACT_NONE, 7'($urandom), $urandom);
    endtask

    // Response side: random stalls, plus one long hold that backs up the block.
    initial begin
        int stall_left;
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && ledger != null && ledger.replies_seen >= 120) begin
                long_hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            ledger.check_response(rsp_ch.status, rsp_ch.granted_index, rsp_ch.read_value,
                                  rsp_ch.occupied_count);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int  goal;
        int  kind;
        int  extra;
        int  target;
        bit  paused;
        ledger            = new();
        calm              = 1'b0;
        long_hold_done    = 1'b0;
        work_words        = 0;
        paused            = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_NONE;
        req_ch.slot_index = '0;
        req_ch.item_value = '0;
        i_rst_n           = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty slots, ignored action, extreme values, reuse of a freed slot.
        send_word(ACT_GET, 0, 32'h0);
        send_word(ACT_FREE, -64, 32'hFFFF_FFFF);
        send_word(ACT_GET, 63, 32'h0);
        send_word(ACT_FREE, -1, 32'h0);
        send_word(ACT_NONE, -1, 32'hFFFF_FFFF);
        send_word(ACT_PUT, 63, 32'h0000_0000);
        send_word(ACT_PUT, -64, 32'hFFFF_FFFF);
        send_word(ACT_PUT, 0, 32'hAAAA_AAAA);
        send_word(ACT_PUT, -1, 32'h5555_5555);
        send_word(ACT_GET, 0, 32'h0);
        send_word(ACT_GET, -63, 32'h0);
        send_word(ACT_GET, 2, 32'h0);
        send_word(ACT_GET, -61, 32'h0);
        send_word(ACT_FREE, 1, 32'h0);
        send_word(ACT_GET, 1, 32'h0);
        send_word(ACT_PUT, 0, 32'h1357_9BDF);
        send_word(ACT_GET, -63, 32'h0);
        send_word(ACT_FREE, -64, 32'h0);
        send_word(ACT_FREE, 0, 32'h0);
        send_word(ACT_NONE, 0, 32'h0);
        send_word(ACT_PUT, 5, 32'h8000_0001);
        wait_drained();

        goal = work_words + ITEM_TARGET;
        while (work_words < goal) begin
            calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                extra = $urandom_range(1, 3);
                while (ledger.occupied < TABLE_SLOTS)
                    send_word(ACT_PUT, 7'($urandom), $urandom);
                repeat (extra) send_word(ACT_PUT, 7'($urandom), $urandom);
            end else if (kind < 5) begin
                target = $urandom_range(0, ledger.occupied);
                while (ledger.occupied > target)
                    send_word(ACT_FREE, as_index(ledger.pick_taken()), $urandom);
            end else begin
                repeat ($urandom_range(20, 40)) mixed_word();
            end
            if (!paused && work_words >= goal - ITEM_TARGET / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d puts, %0d gets, %0d frees and %0d ignored words in %0d responses.",
                 ledger.puts, ledger.gets, ledger.frees, ledger.idle_words,
                 ledger.replies_seen);
        $display("Saw %0d full-table refusals, %0d empty-slot replies, peak occupancy %0d.",
                 ledger.full_refusals, ledger.empty_hits, ledger.peak);
        if (ledger.mismatches == 0 && ledger.expected_replies.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatched fields, %0d responses missing", ledger.mismatches,
                     ledger.expected_replies.size());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/bsa_pkg.sv
hdl/bsa_if.sv
hdl/bsa_ram.sv
hdl/bsa_ctrl.sv
hdl/bsa_dp.sv
hdl/bitmap_slot_allocator.sv
tb/bitmap_slot_allocator_tb.sv
